// File: rtl/sctlc_pkg.sv
// shared types and constants of the sector cache tag and lru controller
// no dependencies; used by sector_cache_tag_lru_controller_core
`default_nettype none

package sctlc_pkg;

   localparam int DEF_NUM_LINES = 64;
   localparam int SECTOR_BYTES  = 512;

   localparam int MODE_W  = 2;
   localparam int DEV_W   = 4;
   localparam int SEC_W   = 48;
   localparam int CNT_W   = 16;
   localparam int SSZ_W   = 16;
   localparam int ACT_W   = 3;
   localparam int LINE_W  = 6;
   localparam int STAMP_W = 64;
   localparam int TAG_W   = DEV_W + SEC_W;

   typedef enum logic [MODE_W-1:0] {
      MODE_READ  = 2'd0,
      MODE_FILL  = 2'd1,
      MODE_WRITE = 2'd2,
      MODE_NONE  = 2'd3
   } mode_type;

   typedef enum logic [ACT_W-1:0] {
      ACT_BYPASS = 3'd0,
      ACT_HIT    = 3'd1,
      ACT_MISS   = 3'd2,
      ACT_STORED = 3'd3,
      ACT_INVAL  = 3'd4
   } action_type;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_SCAN,
      ST_DRAIN,
      ST_FINISH
   } state_type;

endpackage

`default_nettype wire

// File: rtl/sector_cache_tag_lru_controller_core.sv
// tag and lru replacement controller of a fully associative write-through sector cache
// depends on sctlc_pkg (types, field widths, default line count)
`default_nettype none

// usage
//  - request channel: req_* fields are taken at a rising edge where start is high and
//    busy is low; busy stays high until the request has been answered
//  - result channel: rsp_strobe is high for exactly one cycle with rsp_action and
//    rsp_line_index valid; the receiver cannot stall, so it must take the result then
//  - a cacheable read or fill, and any write, walks every line once: the tag and stamp
//    memories are read one line per cycle (one registered read port each),
//    compared in the next cycle, and the outcome is written back in a finish cycle
//  - a walked request passes the scan, drain and finish states before the result strobe;
//    a bypassed request goes straight to finish; busy drops during the strobe cycle, so
//    a new request can be taken in that cycle but not while one is still in flight
//  - the line walk over the memory read port sets the time to answer a walked request
//  - one walk finds the first matching line, the first invalid line from line 1 on and
//    the least stamp; a non-cacheable write clears matching valid bits during the walk
//  - reset clears the valid bits, the use clock and the fsm; memory contents are only
//    looked at behind a valid bit, except the stamp of line 0, which reads as zero
//    until first written
//  - no clearing pass is needed, a request can be accepted right after reset
module sector_cache_tag_lru_controller_core #(
   parameter int NUM_LINES = sctlc_pkg::DEF_NUM_LINES
) (
   input  wire logic                        clock,
   input  wire logic                        reset,
   // request channel
   input  wire logic                        start,
   output logic                             busy,
   input  wire logic [sctlc_pkg::MODE_W-1:0] req_mode,
   input  wire logic [sctlc_pkg::DEV_W-1:0]  req_dev_id,
   input  wire logic [sctlc_pkg::SEC_W-1:0]  req_sector,
   input  wire logic [sctlc_pkg::CNT_W-1:0]  req_sector_count,
   input  wire logic [sctlc_pkg::SSZ_W-1:0]  req_dev_sector_size,
   // result channel
   output logic                             rsp_strobe,
   output logic [sctlc_pkg::ACT_W-1:0]       rsp_action,
   output logic [sctlc_pkg::LINE_W-1:0]      rsp_line_index
);

   localparam int IDX_W = $clog2(NUM_LINES);
   localparam int XW    = (IDX_W > sctlc_pkg::LINE_W) ? IDX_W : sctlc_pkg::LINE_W;
   localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(NUM_LINES - 1);

   // memories: tag {device, sector} and lru stamp per line
   logic [sctlc_pkg::TAG_W-1:0]   tag_mem   [NUM_LINES];
   logic [sctlc_pkg::STAMP_W-1:0] stamp_mem [NUM_LINES];
   logic [sctlc_pkg::TAG_W-1:0]   tag_rd_ff;
   logic [sctlc_pkg::STAMP_W-1:0] stamp_rd_ff;

   // fsm
   sctlc_pkg::state_type state_ff, state_in;

   // latched request
   sctlc_pkg::mode_type          mode_ff, mode_in;
   logic [sctlc_pkg::DEV_W-1:0]  dev_ff, dev_in;
   logic [sctlc_pkg::SEC_W-1:0]  sec_ff, sec_in;
   logic [sctlc_pkg::SEC_W:0]    end_ff, end_in;      // sector + count, one bit wider
   logic                         cache_ff, cache_in;

   // walk pipeline
   logic [IDX_W-1:0] addr_ff, addr_in;
   logic             rd_vld_ff, rd_vld_in;
   logic [IDX_W-1:0] rd_idx_ff, rd_idx_in;

   // walk results
   logic                          match_found_ff, match_found_in;
   logic [IDX_W-1:0]              match_idx_ff, match_idx_in;
   logic                          inv_found_ff, inv_found_in;
   logic [IDX_W-1:0]              inv_idx_ff, inv_idx_in;
   logic [IDX_W-1:0]              best_idx_ff, best_idx_in;
   logic [sctlc_pkg::STAMP_W-1:0] best_stamp_ff, best_stamp_in;

   // cache control state
   logic [NUM_LINES-1:0]          valid_ff, valid_in;
   logic                          stamp0_wr_ff, stamp0_wr_in;
   logic [sctlc_pkg::STAMP_W-1:0] use_clock_ff, use_clock_in;

   // result registers
   logic                         rsp_strobe_ff, rsp_strobe_in;
   sctlc_pkg::action_type        rsp_action_ff, rsp_action_in;
   logic [sctlc_pkg::LINE_W-1:0] rsp_line_ff, rsp_line_in;

   // request decode
   logic accept;
   logic req_cacheable;
   logic need_walk;

   // compare stage
   logic                          line_v;
   logic [sctlc_pkg::DEV_W-1:0]   line_dev;
   logic [sctlc_pkg::SEC_W-1:0]   line_sec;
   logic [sctlc_pkg::STAMP_W-1:0] line_stamp;
   logic                          tag_hit;
   logic                          range_hit;

   // finish stage outputs
   logic                          mem_rd_en;
   logic                          store_go;
   logic                          bump_go;
   logic [IDX_W-1:0]              fin_idx;
   logic [XW-1:0]                 fin_idx_x;
   sctlc_pkg::action_type         fin_action;

   assign accept        = start && !busy;
   assign req_cacheable = (req_sector_count == sctlc_pkg::CNT_W'(1)) &&
                          ((req_dev_sector_size == '0) ||
                           (req_dev_sector_size == sctlc_pkg::SSZ_W'(sctlc_pkg::SECTOR_BYTES)));
   assign need_walk     = ((req_mode == sctlc_pkg::MODE_READ || req_mode == sctlc_pkg::MODE_FILL)
                           && req_cacheable) || (req_mode == sctlc_pkg::MODE_WRITE);

   assign busy           = (state_ff != sctlc_pkg::ST_IDLE);
   assign rsp_strobe     = rsp_strobe_ff;
   assign rsp_action     = rsp_action_ff;
   assign rsp_line_index = rsp_line_ff;

   // tag memory: read during the walk, written in the finish cycle
   always_ff @(posedge clock) begin
      if (store_go) begin
         tag_mem[fin_idx] <= {dev_ff, sec_ff};
      end
      if (mem_rd_en) begin
         tag_rd_ff <= tag_mem[addr_ff];
      end
   end

   // stamp memory: same access pattern, written on every hit or store
   always_ff @(posedge clock) begin
      if (bump_go) begin
         stamp_mem[fin_idx] <= use_clock_ff + sctlc_pkg::STAMP_W'(1);
      end
      if (mem_rd_en) begin
         stamp_rd_ff <= stamp_mem[addr_ff];
      end
   end

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         sctlc_pkg::ST_IDLE: begin
            if (accept) begin
               state_in = need_walk ? sctlc_pkg::ST_SCAN : sctlc_pkg::ST_FINISH;
            end
         end
         sctlc_pkg::ST_SCAN: begin
            if (addr_ff == LAST_IDX) begin
               state_in = sctlc_pkg::ST_DRAIN;
            end
         end
         sctlc_pkg::ST_DRAIN:  state_in = sctlc_pkg::ST_FINISH;
         sctlc_pkg::ST_FINISH: state_in = sctlc_pkg::ST_IDLE;
         default:              state_in = sctlc_pkg::ST_IDLE;
      endcase
   end

   // fsm outputs: memory read enable and the finish decision
   always_comb begin
      mem_rd_en  = (state_ff == sctlc_pkg::ST_SCAN);
      store_go   = 1'b0;
      bump_go    = 1'b0;
      fin_idx    = '0;
      fin_action = sctlc_pkg::ACT_BYPASS;
      if (state_ff == sctlc_pkg::ST_FINISH) begin
         priority if (mode_ff == sctlc_pkg::MODE_READ && cache_ff) begin
            if (match_found_ff) begin
               bump_go    = 1'b1;
               fin_idx    = match_idx_ff;
               fin_action = sctlc_pkg::ACT_HIT;
            end else begin
               fin_action = sctlc_pkg::ACT_MISS;
            end
         end else if ((mode_ff == sctlc_pkg::MODE_FILL || mode_ff == sctlc_pkg::MODE_WRITE)
                      && cache_ff) begin
            store_go   = 1'b1;
            bump_go    = 1'b1;
            fin_action = sctlc_pkg::ACT_STORED;
            // existing line, else first invalid line from line 1, else least stamp
            if (match_found_ff) begin
               fin_idx = match_idx_ff;
            end else if (inv_found_ff) begin
               fin_idx = inv_idx_ff;
            end else begin
               fin_idx = best_idx_ff;
            end
         end else if (mode_ff == sctlc_pkg::MODE_WRITE) begin
            fin_action = sctlc_pkg::ACT_INVAL;
         end else begin
            fin_action = sctlc_pkg::ACT_BYPASS;
         end
      end
   end

   assign fin_idx_x = XW'(fin_idx);

   // compare stage on the registered memory data
   assign line_v     = valid_ff[rd_idx_ff];
   assign line_dev   = tag_rd_ff[sctlc_pkg::TAG_W-1 -: sctlc_pkg::DEV_W];
   assign line_sec   = tag_rd_ff[sctlc_pkg::SEC_W-1:0];
   // line 0 stamp reads as zero until first written
   assign line_stamp = ((rd_idx_ff == '0) && !stamp0_wr_ff) ? '0 : stamp_rd_ff;
   assign tag_hit    = line_v && (line_dev == dev_ff) && (line_sec == sec_ff);
   assign range_hit  = line_v && (line_dev == dev_ff) && (line_sec >= sec_ff) &&
                       ({1'b0, line_sec} < end_ff);

   // datapath next values
   always_comb begin
      mode_in        = mode_ff;
      dev_in         = dev_ff;
      sec_in         = sec_ff;
      end_in         = end_ff;
      cache_in       = cache_ff;
      addr_in        = addr_ff;
      rd_vld_in      = 1'b0;
      rd_idx_in      = rd_idx_ff;
      match_found_in = match_found_ff;
      match_idx_in   = match_idx_ff;
      inv_found_in   = inv_found_ff;
      inv_idx_in     = inv_idx_ff;
      best_idx_in    = best_idx_ff;
      best_stamp_in  = best_stamp_ff;
      valid_in       = valid_ff;
      stamp0_wr_in   = stamp0_wr_ff;
      use_clock_in   = use_clock_ff;
      rsp_strobe_in  = 1'b0;
      rsp_action_in  = rsp_action_ff;
      rsp_line_in    = rsp_line_ff;

      if (accept) begin
         mode_in        = sctlc_pkg::mode_type'(req_mode);
         dev_in         = req_dev_id;
         sec_in         = req_sector;
         end_in         = {1'b0, req_sector} + (sctlc_pkg::SEC_W + 1)'(req_sector_count);
         cache_in       = req_cacheable;
         addr_in        = '0;
         match_found_in = 1'b0;
         inv_found_in   = 1'b0;
      end

      // issue one line read per cycle
      if (mem_rd_en) begin
         rd_vld_in = 1'b1;
         rd_idx_in = addr_ff;
         addr_in   = addr_ff + IDX_W'(1);
      end

      if (rd_vld_ff) begin
         if (tag_hit && !match_found_ff) begin
            match_found_in = 1'b1;
            match_idx_in   = rd_idx_ff;
         end
         if (rd_idx_ff == '0) begin
            best_idx_in   = '0;
            best_stamp_in = line_stamp;
         end else if (!inv_found_ff) begin
            if (!line_v) begin
               inv_found_in = 1'b1;
               inv_idx_in   = rd_idx_ff;
            end else if (line_stamp < best_stamp_ff) begin
               best_idx_in   = rd_idx_ff;
               best_stamp_in = line_stamp;
            end
         end
         // range invalidation for a non-cacheable write
         if (mode_ff == sctlc_pkg::MODE_WRITE && !cache_ff && range_hit) begin
            valid_in[rd_idx_ff] = 1'b0;
         end
      end

      if (store_go) begin
         valid_in[fin_idx] = 1'b1;
      end
      if (bump_go) begin
         use_clock_in = use_clock_ff + sctlc_pkg::STAMP_W'(1);
         if (fin_idx == '0) begin
            stamp0_wr_in = 1'b1;
         end
      end

      if (state_ff == sctlc_pkg::ST_FINISH) begin
         rsp_strobe_in = 1'b1;
         rsp_action_in = fin_action;
         rsp_line_in   = fin_idx_x[sctlc_pkg::LINE_W-1:0];
      end
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= sctlc_pkg::ST_IDLE;
         rd_vld_ff     <= 1'b0;
         valid_ff      <= '0;
         stamp0_wr_ff  <= 1'b0;
         use_clock_ff  <= '0;
         rsp_strobe_ff <= 1'b0;
      end else begin
         state_ff      <= state_in;
         rd_vld_ff     <= rd_vld_in;
         valid_ff      <= valid_in;
         stamp0_wr_ff  <= stamp0_wr_in;
         use_clock_ff  <= use_clock_in;
         rsp_strobe_ff <= rsp_strobe_in;
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      mode_ff        <= mode_in;
      dev_ff         <= dev_in;
      sec_ff         <= sec_in;
      end_ff         <= end_in;
      cache_ff       <= cache_in;
      addr_ff        <= addr_in;
      rd_idx_ff      <= rd_idx_in;
      match_found_ff <= match_found_in;
      match_idx_ff   <= match_idx_in;
      inv_found_ff   <= inv_found_in;
      inv_idx_ff     <= inv_idx_in;
      best_idx_ff    <= best_idx_in;
      best_stamp_ff  <= best_stamp_in;
      rsp_action_ff  <= rsp_action_in;
      rsp_line_ff    <= rsp_line_in;
   end

   // the walk pipeline is empty when the decision is taken
   a_drained_at_finish: assert property (@(posedge clock) disable iff (reset)
      (state_ff == sctlc_pkg::ST_FINISH) |-> !rd_vld_ff)
      else $error("line walk still in flight at finish");

   // a result only follows a finish cycle
   a_strobe_after_finish: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe_ff |-> $past(state_ff == sctlc_pkg::ST_FINISH))
      else $error("result strobe without finish");

   // a stored line is valid afterwards
   a_store_sets_valid: assert property (@(posedge clock) disable iff (reset)
      store_go |=> valid_ff[$past(fin_idx)])
      else $error("stored line not valid");

   // the use clock only moves on a hit or store
   a_clock_moves_on_bump: assert property (@(posedge clock) disable iff (reset)
      (use_clock_ff != $past(use_clock_ff)) |-> $past(bump_go))
      else $error("use clock moved without hit or store");

endmodule

`default_nettype wire
